>>> rtl/core/address_stack_with_remove_defines.svh
// Assertion macros shared by the address stack RTL.
`ifndef ADDRESS_STACK_WITH_REMOVE_DEFINES_SVH
`define ADDRESS_STACK_WITH_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("address stack assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("address stack assertion failed");
`else
`define ASR_ASSERT(lbl, prop)
`define ASR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/asr_pkg.sv
// Package with the types, codes and constants of the address stack.
`default_nettype none

package asr_pkg;

    localparam int ASR_DEPTH     = 16;
    localparam int ASR_WORD_BITS = 32;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_EMPTY   = 2'd2,
        STS_NOMATCH = 2'd3
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0]  top_value;
        logic                top_valid;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_TOP_RD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_TOP
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        logic    exec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    idx_dec;
        logic    idx_inc;
        logic    mem_shift_wr;
        logic    set_nomatch;
        logic    count_dec;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic is_remove;
        logic empty;
        logic match;
        logic idx_zero;
        logic shift_more;
        logic rsp_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/asr_dp.sv
// Datapath of the address stack: entry memory, fill count, search index and response register.
`default_nettype none
`include "address_stack_with_remove_defines.svh"

module asr_dp
    import asr_pkg::*;
#(
    parameter int DEPTH     = ASR_DEPTH,
    parameter int WORD_BITS = ASR_WORD_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [WORD_BITS-1:0] r_value;
    logic [FUNC_W-1:0]    r_func;
    logic [CNT_W-1:0]     r_count;
    logic [AW-1:0]        r_idx;
    t_status              r_status;
    t_rsp                 r_rsp;
    logic                 r_rsp_valid;

    logic                 full;
    logic                 empty;
    logic                 is_push;
    logic                 is_pop;
    logic                 is_remove;
    logic                 is_clear;
    t_status              exec_status;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    t_rsp                 n_rsp;

    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == CNT_W'(0));
    assign is_push   = (r_func == FN_PUSH);
    assign is_pop    = (r_func == FN_POP);
    assign is_remove = (r_func == FN_REMOVE);
    assign is_clear  = (r_func == FN_CLEAR);

    always_comb begin
        priority if (is_push && full) begin
            exec_status = STS_FULL;
        end else if (is_pop && empty) begin
            exec_status = STS_EMPTY;
        end else if (is_remove && empty) begin
            exec_status = STS_NOMATCH;
        end else begin
            exec_status = STS_OK;
        end
    end

    // One write port: pushes write at the fill count, the gap close writes at the index.
    assign mem_we  = (i_cmd.exec && is_push && !full) || i_cmd.mem_shift_wr;
    assign wr_addr = i_cmd.mem_shift_wr ? r_idx : AW'(r_count);
    assign wr_data = i_cmd.mem_shift_wr ? r_rd_data : r_value;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_IDX:  rd_addr = r_idx;
            RD_NEXT: rd_addr = r_idx + AW'(1);
            RD_TOP:  rd_addr = AW'(r_count - CNT_W'(1));
            default: rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_rsp.top_value   = empty ? '0 : VALUE_W'(r_rd_data);
        n_rsp.top_valid   = !empty;
        n_rsp.entry_count = COUNT_W'(r_count);
        n_rsp.status      = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                priority if (is_push && !full) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (is_pop && !empty) begin
                    r_count <= r_count - CNT_W'(1);
                end else if (is_clear) begin
                    r_count <= '0;
                end else begin
                    // Queries, refused requests and removes keep the count here.
                end
            end
            if (i_cmd.count_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_req.func;
            r_value <= WORD_BITS'(i_req.value);
        end
        if (i_cmd.exec) begin
            r_status <= exec_status;
            r_idx    <= AW'(r_count - CNT_W'(1));
        end
        if (i_cmd.idx_dec) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.set_nomatch) begin
            r_status <= STS_NOMATCH;
        end
        if (i_cmd.load_out) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.is_remove  = is_remove;
    assign o_sts.empty      = empty;
    assign o_sts.match      = (r_rd_data == r_value);
    assign o_sts.idx_zero   = (r_idx == AW'(0));
    assign o_sts.shift_more = ((CNT_W'(r_idx) + CNT_W'(1)) < r_count);
    assign o_sts.rsp_free   = !r_rsp_valid || i_rsp_ready;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `ASR_ASSERT(a_count_max, r_count <= CNT_W'(DEPTH))
    `ASR_ASSERT(a_shift_in_range, !i_cmd.mem_shift_wr || ((CNT_W'(r_idx) + CNT_W'(1)) < r_count))
    `ASR_ASSERT_NEXT(a_push_full, i_cmd.exec && is_push && full, (r_status == STS_FULL) && $stable(r_count))

endmodule

`default_nettype wire

>>> rtl/core/asr_ctrl.sv
// Controller state machine of the address stack.
`default_nettype none
`include "address_stack_with_remove_defines.svh"

module asr_ctrl
    import asr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_remove && !i_sts.empty) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_SRCH_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                priority if (i_sts.match) begin
                    n_state = S_SHIFT_CHK;
                end else if (i_sts.idx_zero) begin
                    o_cmd.set_nomatch = 1'b1;
                    n_state           = S_TOP_RD;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_SHIFT_CHK: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_SHIFT_WR;
                end else begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_TOP_RD;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.mem_shift_wr = 1'b1;
                o_cmd.idx_inc      = 1'b1;
                n_state            = S_SHIFT_CHK;
            end
            S_TOP_RD: begin
                o_cmd.rd_en  = !i_sts.empty;
                o_cmd.rd_sel = RD_TOP;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.rsp_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASR_ASSERT_NEXT(a_accept_to_exec, i_req_valid && o_req_ready, r_state == S_EXEC)
    `ASR_ASSERT(a_cmp_after_read, (r_state != S_SRCH_CMP) || ($past(r_state) == S_SRCH_RD))
    `ASR_ASSERT_NEXT(a_done_to_idle, (r_state == S_DONE) && i_sts.rsp_free, r_state == S_IDLE)

endmodule

`default_nettype wire

>>> rtl/core/address_stack_with_remove.sv
// Top level of the bounded address stack with remove by value.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+----------------------------------------
//  request | in        | i_req_valid / o_req_ready | i_req: func, value
//  result  | out       | o_rsp_valid / i_rsp_ready | o_rsp: top_value, top_valid,
//          |           |                           |        entry_count, status
//
// Push, pop, clear and query pass from acceptance to the result register in
// these steps: capture, execute, read of the top entry, and load of the result.
// Remove by value searches from the top down, reading an entry and then comparing
// it, then moves each entry above the match down by one (read, then write); the
// entry memory has a single read port, so each read takes a step of its own.
// Reset clears the fill count, the state machine and the result valid flag;
// the entry memory is not cleared, since only written entries are ever read.
// A new request is taken while an earlier result still waits in the result
// register; a stalled result holds the block in its last step until taken.
`default_nettype none

module address_stack_with_remove
    import asr_pkg::*;
#(
    parameter int DEPTH     = ASR_DEPTH,
    parameter int WORD_BITS = ASR_WORD_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    // Commands run from the controller to the datapath; status comes back.
    t_cmd cmd;
    t_sts sts;

    // The controller sequences each request: a single execute step for push, pop,
    // clear and query, and a search loop followed by a gap-closing loop for remove.
    asr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the entries, the fill count and the result register.
    asr_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

>>> tb/asr_stack_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every stack result from the accepted requests and compares.
module asr_stack_checker
    import asr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow copy of the stack; slot 0 is the bottom.
    logic [ASR_WORD_BITS-1:0] stack_words [ASR_DEPTH];
    int                       stack_fill;
    t_rsp                     predicted_rsps [$];
    t_rsp                     oldest_rsp;
    int                       fail_count = 0;

    // Applies one request to the shadow stack and returns the result it must give.
    function automatic t_rsp stack_step(t_req r);
        t_rsp                     res;
        t_status                  st;
        int                       hit;
        logic [ASR_WORD_BITS-1:0] v;
        st  = STS_OK;
        hit = -1;
        v   = r.value[ASR_WORD_BITS-1:0];
        case (r.func)
            FN_PUSH: begin
                if (stack_fill >= ASR_DEPTH) begin
                    st = STS_FULL;
                end else begin
                    stack_words[stack_fill] = v;
                    stack_fill++;
                end
            end
            FN_POP: begin
                if (stack_fill == 0) begin
                    st = STS_EMPTY;
                end else begin
                    stack_fill--;
                end
            end
            FN_REMOVE: begin
                for (int i = stack_fill - 1; i >= 0; i--) begin
                    if (hit < 0 && stack_words[i] == v) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    st = STS_NOMATCH;
                end else begin
                    for (int j = hit; j + 1 < stack_fill; j++) begin
                        stack_words[j] = stack_words[j + 1];
                    end
                    stack_fill--;
                end
            end
            FN_CLEAR: begin
                stack_fill = 0;
            end
            default: begin
            end
        endcase
        res.top_valid   = (stack_fill > 0);
        res.top_value   = (stack_fill > 0) ? stack_words[stack_fill - 1] : '0;
        res.entry_count = COUNT_W'(stack_fill);
        res.status      = st;
        return res;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_fill = 0;
            predicted_rsps.delete();
        end else begin
            // A result is always older than a request taken at the same edge.
            if (i_rsp_valid && i_rsp_ready) begin
                if (predicted_rsps.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, i_rsp);
                    fail_count++;
                end else begin
                    oldest_rsp = predicted_rsps.pop_front();
                    check_field("top_value", oldest_rsp.top_value, i_rsp.top_value);
                    check_field("top_valid", VALUE_W'(oldest_rsp.top_valid),
                                VALUE_W'(i_rsp.top_valid));
                    check_field("entry_count", VALUE_W'(oldest_rsp.entry_count),
                                VALUE_W'(i_rsp.entry_count));
                    check_field("status", VALUE_W'(oldest_rsp.status), VALUE_W'(i_rsp.status));
                end
            end
            if (i_req_valid && i_req_ready) begin
                predicted_rsps.push_back(stack_step(i_req));
            end
        end
        o_pending    <= predicted_rsps.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives requests into the address stack and gives the verdict.
module tb;
    import asr_pkg::*;

    // Query-only code and the highest func code; codes above the query are unused
    // and must behave as a query.
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;
    localparam logic [FUNC_W-1:0] FN_MAX   = 3'd7;

    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 137;
    localparam int TREND_LEN       = 48;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int LONG_HOLD       = 300;
    // Sized to cover a remove that walks the whole stack.
    localparam int DRAIN_CYCLES    = 4 * ASR_DEPTH + 8;
    // Cycles without any handshake before the run is declared hung. The worst
    // correct case is the long hold-off plus a full remove, so this is ample.
    localparam int STALL_LIMIT     = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // Idle percentages for the current phase, read by the two driving processes.
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_request  = 1'b0;

    // Pool of addresses per phase, so that removes often find a match.
    logic [VALUE_W-1:0] addr_pool [8];
    logic [VALUE_W-1:0] last_pushed;
    logic [VALUE_W-1:0] word;
    logic [FUNC_W-1:0]  fn;
    int                 roll;
    int                 push_pct;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    address_stack_with_remove dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    asr_stack_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one request and holds it until the block takes it. Valid stays high
    // into the next request unless an idle gap is drawn, so valid is never
    // lowered and raised within one time step.
    task automatic send_req(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
        i_req_valid <= 1'b1;
        i_req       <= '{func: func, value: value};
        do @(posedge i_clk); while (!o_req_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Receiver side. It stalls at random at the phase rate, and once on request it
    // holds off for a long stretch, counted here, while the sender keeps offering.
    initial begin
        i_rsp_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Watchdog: any handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL address_stack_with_remove");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with no idling. The empty-stack cases come first.
        send_req(FN_QUERY, 32'h0000_0000);
        send_req(FN_POP, 32'h0000_0000);
        send_req(FN_REMOVE, 32'h0000_0000);
        send_req(FN_CLEAR, 32'hFFFF_FFFF);
        // Fill to the brim; zero appears twice so that remove must pick the upper one.
        for (int k = 0; k < ASR_DEPTH; k++) begin
            case (k)
                0, 6:    word = 32'h0000_0000;
                1:       word = 32'hFFFF_FFFF;
                2:       word = 32'hAAAA_AAAA;
                3:       word = 32'h5555_5555;
                default: word = $urandom;
            endcase
            send_req(FN_PUSH, word);
            last_pushed = word;
        end
        // Push into a full stack is refused.
        send_req(FN_PUSH, 32'hDEAD_BEEF);
        // Remove the top entry itself, then the upper zero, then the one at the bottom.
        send_req(FN_REMOVE, last_pushed);
        send_req(FN_REMOVE, 32'h0000_0000);
        send_req(FN_REMOVE, 32'h0000_0000);
        // No zero is left, so this remove finds nothing.
        send_req(FN_REMOVE, 32'h0000_0000);
        // Unused codes behave as a query.
        send_req(FN_QUERY + 3'd1, 32'hFFFF_FFFF);
        send_req(FN_MAX, 32'h1234_5678);
        send_req(FN_POP, 32'h0000_0000);
        send_req(FN_CLEAR, 32'h0000_0000);

        // Random part in four phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; rsp_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rsp_stall_pct = 49; end
                default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
            endcase
            for (int p = 0; p < 8; p++) begin
                addr_pool[p] = $urandom;
            end
            // The long hold-off comes early in the first phase, during a burst.
            if (phase == 0) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Alternate stretches that lean toward filling and toward draining,
                // so that both the full and the empty corners are reached often.
                push_pct = ((n / TREND_LEN) % 2 == 0) ? 60 : 25;
                roll     = $urandom_range(99);
                if (roll < push_pct) begin
                    fn = FN_PUSH;
                end else if (roll < push_pct + 20) begin
                    fn = FN_POP;
                end else if (roll < push_pct + 35) begin
                    fn = FN_REMOVE;
                end else if (roll < push_pct + 36) begin
                    fn = FN_CLEAR;
                end else if (roll < push_pct + 39) begin
                    fn = FN_QUERY;
                end else if (roll < push_pct + 41) begin
                    fn = FN_LOGIC_UNUSED();
                end else begin
                    fn = FN_POP;
                end
                if ($urandom_range(99) < 85) begin
                    word = addr_pool[$urandom_range(7)];
                end else begin
                    word = $urandom;
                end
                send_req(fn, word);
            end
        end

        // Let the last request's expectation land, then wait for every result.
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS address_stack_with_remove");
        end else begin
            $display("FAIL address_stack_with_remove");
        end
        $finish;
    end

    // Draws one of the unused func codes above the query code.
    function automatic logic [FUNC_W-1:0] FN_LOGIC_UNUSED();
        return FUNC_W'($urandom_range(int'(FN_MAX), int'(FN_QUERY) + 1));
    endfunction

endmodule
